// File: rtl/stis_pkg.sv
// Shared types and constants for the sorted timestamp index search unit.
// No dependencies; used by the controller, the datapath and the top level.
package stis_pkg;

   // Default number of table entries.
   localparam int TABLE_DEPTH_DEFAULT = 1024;

   // Fixed field widths.
   localparam int OPCODE_W   = 2;
   localparam int STAMP_W    = 64;
   localparam int OFFSET_W   = 26;
   localparam int COUNT_W    = 11;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 1;

   // Register reset values.
   localparam logic [CSR_DATA_W-1:0] HEADER_BYTES_RESET = 16'd32;
   localparam logic [CSR_DATA_W-1:0] RECORD_BYTES_RESET = 16'd64;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_BYTES = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECORD_BYTES = 1'b1;

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_CLEAR       = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_APPEND      = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LOWER_BOUND = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_UPPER_BOUND = 2'd3;

   // Request payload.
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [STAMP_W-1:0]  timestamp;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic                found;
      logic [COUNT_W-1:0]  held_count;
      logic                dropped;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;       // latch request, start search bounds
      logic clear;      // empty the table
      logic probe_rd;   // read entry at search midpoint
      logic probe_upd;  // narrow search bounds from read entry
      logic shift_rd;   // read entry below the shift pointer
      logic shift_wr;   // move read entry up one place
      logic insert;     // write new entry at search position
      logic fetch_rd;   // read entry at search position
      logic mult;       // register record number times record size
      logic respond;    // load response register
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                search_done;
      logic                full;
      logic                at_insert;
      logic                hit;
   } stat_type;

endpackage

// File: rtl/sorted_timestamp_index_search_unit.sv
// Top level of the sorted timestamp index search unit: controller plus datapath.
// Depends on stis_pkg, stis_controller and stis_datapath.
//
//  channel   ports                                   handshake
//  request   start, busy, req_payload                taken when start & !busy
//  response  rsp_valid, rsp_payload                  one-cycle strobe
//  config    csr_we, csr_index, csr_wdata            written when csr_we
//
// With P binary search probes (P <= ceil(log2(count+1))) and S entries moved up for
// an append: a clear or a dropped append goes from decode to the response; a query
// runs P probes, then a fetch and a multiply on a hit; an append runs P probes, S
// moves and an insert. Each probe is a read then a compare, each move a read then
// a write, on the table memory, whose read data is registered. A new request is
// taken in the cycle of the strobe. Reset (synchronous) empties the table and
// restores the registers; the response side never stalls.
module sorted_timestamp_index_search_unit #(
   parameter int TABLE_DEPTH = stis_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  stis_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   output stis_pkg::rsp_type                rsp_payload,
   input  logic                             csr_we,
   input  logic [stis_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [stis_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   stis_pkg::cmd_type  cmd;
   stis_pkg::stat_type stat;

   stis_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   stis_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // A response is a single-cycle strobe
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // An accepted request keeps the unit busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after accepting a request");

   // The strobe comes only once the unit is idle again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // A dropped append never reports a hit or an offset
   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.dropped) |->
         (!rsp_payload.found && (rsp_payload.offset == '0)))
      else $error("dropped append reports a hit");

endmodule

// File: rtl/stis_controller.sv
// Sequencing state machine for the sorted timestamp index search unit.
// Depends on stis_pkg for command, status and opcode definitions.
module stis_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  stis_pkg::stat_type stat,
   output stis_pkg::cmd_type  cmd,
   output logic              busy
);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_DECODE    = 10'b00_0000_0010,
      ST_PROBE_RD  = 10'b00_0000_0100,
      ST_PROBE_CMP = 10'b00_0000_1000,
      ST_SHIFT_RD  = 10'b00_0001_0000,
      ST_SHIFT_WR  = 10'b00_0010_0000,
      ST_INSERT    = 10'b00_0100_0000,
      ST_FETCH     = 10'b00_1000_0000,
      ST_MULT      = 10'b01_0000_0000,
      ST_RESPOND   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.op)
               stis_pkg::OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_RESPOND;
               end
               stis_pkg::OP_APPEND: begin
                  state_in = stat.full ? ST_RESPOND : ST_PROBE_RD;
               end
               default: begin
                  state_in = ST_PROBE_RD;
               end
            endcase
         end
         ST_PROBE_RD: begin
            if (stat.search_done) begin
               if (stat.op == stis_pkg::OP_APPEND) begin
                  state_in = ST_SHIFT_RD;
               end else if (stat.hit) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_RESPOND;
               end
            end else begin
               cmd.probe_rd = 1'b1;
               state_in     = ST_PROBE_CMP;
            end
         end
         ST_PROBE_CMP: begin
            cmd.probe_upd = 1'b1;
            state_in      = ST_PROBE_RD;
         end
         // Open a slot at the search position, one entry per read and write state pair
         ST_SHIFT_RD: begin
            if (stat.at_insert) begin
               state_in = ST_INSERT;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = ST_SHIFT_RD;
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = ST_RESPOND;
         end
         ST_FETCH: begin
            cmd.fetch_rd = 1'b1;
            state_in     = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: rtl/stis_datapath.sv
// Table memory, search bounds, count, registers and response for the
// sorted timestamp index search unit. Depends on stis_pkg.
module stis_datapath #(
   parameter int TABLE_DEPTH = stis_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  stis_pkg::req_type                   req_payload,
   input  logic                                csr_we,
   input  logic [stis_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [stis_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  stis_pkg::cmd_type                   cmd,
   output stis_pkg::stat_type                  stat,
   output logic                                rsp_valid,
   output stis_pkg::rsp_type                   rsp_payload
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = stis_pkg::STAMP_W + IW;
   localparam int PW = IW + stis_pkg::CSR_DATA_W;

   // Table memory: stamp above record number
   logic [EW-1:0] mem [TABLE_DEPTH];
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [EW-1:0] rd_q_ff;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   logic [CW-1:0] count_ff, lo_ff, hi_ff, ptr_ff;
   logic [CW-1:0] mid;
   logic [stis_pkg::OPCODE_W-1:0] op_ff;
   logic [stis_pkg::STAMP_W-1:0]  target_ff;
   logic          dropped_ff;
   logic [stis_pkg::CSR_DATA_W-1:0] header_ff, record_ff;
   logic [PW-1:0] prod_ff;
   logic [PW:0]   sum;
   logic          strict;
   logic          go_right;
   logic          found;
   logic [stis_pkg::STAMP_W-1:0] rd_stamp;
   logic [IW-1:0] rd_recno;
   logic          rsp_valid_ff;
   stis_pkg::rsp_type rsp_ff;

   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rd_stamp = rd_q_ff[EW-1:IW];
   assign rd_recno = rd_q_ff[IW-1:0];

   // Upper bound and append placement skip equal stamps
   assign strict   = (op_ff != stis_pkg::OP_LOWER_BOUND);
   assign go_right = strict ? (rd_stamp <= target_ff) : (rd_stamp < target_ff);

   // Memory port addressing
   always_comb begin
      rd_en   = cmd.probe_rd | cmd.shift_rd | cmd.fetch_rd;
      rd_addr = lo_ff[IW-1:0];
      if (cmd.probe_rd) begin
         rd_addr = mid[IW-1:0];
      end else if (cmd.shift_rd) begin
         rd_addr = IW'(ptr_ff - 1'b1);
      end
      wr_en   = cmd.shift_wr | cmd.insert;
      wr_addr = cmd.shift_wr ? ptr_ff[IW-1:0] : lo_ff[IW-1:0];
      wr_data = cmd.shift_wr ? rd_q_ff : {target_ff, count_ff[IW-1:0]};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (cmd.insert) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // Request latch, search bounds and shift pointer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_payload.opcode;
         target_ff  <= req_payload.timestamp;
         dropped_ff <= (req_payload.opcode == stis_pkg::OP_APPEND) &&
                       (count_ff >= CW'(TABLE_DEPTH));
         lo_ff      <= '0;
         hi_ff      <= count_ff;
         ptr_ff     <= count_ff;
      end else begin
         if (cmd.probe_upd) begin
            if (go_right) begin
               lo_ff <= mid + 1'b1;
            end else begin
               hi_ff <= mid;
            end
         end
         if (cmd.shift_wr) begin
            ptr_ff <= ptr_ff - 1'b1;
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= stis_pkg::HEADER_BYTES_RESET;
         record_ff <= stis_pkg::RECORD_BYTES_RESET;
      end else if (csr_we) begin
         case (csr_index)
            stis_pkg::CSR_HEADER_BYTES: header_ff <= csr_wdata;
            stis_pkg::CSR_RECORD_BYTES: record_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Offset product
   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         prod_ff <= PW'(rd_recno) * PW'(record_ff);
      end
   end

   assign sum   = {1'b0, prod_ff} + (PW + 1)'(header_ff);
   assign found = (op_ff[1] == 1'b1) && (lo_ff < count_ff);

   // Response register, strobed for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.offset     <= found ? stis_pkg::OFFSET_W'(sum) : '0;
         rsp_ff.found      <= found;
         rsp_ff.held_count <= stis_pkg::COUNT_W'(count_ff);
         rsp_ff.dropped    <= dropped_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Status to controller
   assign stat.op          = op_ff;
   assign stat.search_done = (lo_ff >= hi_ff);
   assign stat.full        = (count_ff >= CW'(TABLE_DEPTH));
   assign stat.at_insert   = (ptr_ff == lo_ff);
   assign stat.hit         = (lo_ff < count_ff);

endmodule

// File: test/testbench.sv
// Testbench for sorted_timestamp_index_search_unit: drives clear, append and bound queries,
// predicts every response with a table model held in a scoreboard class, and checks them.
// Depends on stis_pkg and the RTL of the unit only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import stis_pkg::*;

   localparam int DEPTH = TABLE_DEPTH_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 20_000_000;
   localparam logic [STAMP_W-1:0] ALL_ONES = {STAMP_W{1'b1}};

   // Sorted stamp table with its own copy of the size registers; holds the
   // responses still owed by the unit, oldest first.
   class stamp_index_tracker;
      int unsigned           entries;
      logic [STAMP_W-1:0]    stamps [DEPTH];
      int unsigned           record_no [DEPTH];
      logic [CSR_DATA_W-1:0] header_bytes;
      logic [CSR_DATA_W-1:0] record_bytes;
      rsp_type               owed_rsp [$];
      int unsigned           mismatches;

      function new();
         entries      = 0;
         header_bytes = HEADER_BYTES_RESET;
         record_bytes = RECORD_BYTES_RESET;
         mismatches   = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_HEADER_BYTES) begin
            header_bytes = value;
         end else begin
            record_bytes = value;
         end
      endfunction

      // First position whose stamp is >= target, or > target when strict.
      function int unsigned bound_pos(logic [STAMP_W-1:0] target, bit strict);
         int unsigned lo, hi, mid;
         lo = 0;
         hi = entries;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (strict ? (stamps[mid] <= target) : (stamps[mid] < target)) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
         return lo;
      endfunction

      // Apply one accepted request and queue the response it must produce.
      function void take_request(req_type r);
         rsp_type     ans;
         int unsigned pos;
         logic [63:0] off;
         ans = '0;
         case (r.opcode)
            OP_CLEAR: begin
               entries = 0;
            end
            OP_APPEND: begin
               if (entries >= DEPTH) begin
                  ans.dropped = 1'b1;
               end else begin
                  // insert after equal stamps so ties keep arrival order
                  pos = bound_pos(r.timestamp, 1'b1);
                  for (int unsigned i = entries; i > pos; i--) begin
                     stamps[i]    = stamps[i-1];
                     record_no[i] = record_no[i-1];
                  end
                  stamps[pos]    = r.timestamp;
                  record_no[pos] = entries;
                  entries++;
               end
            end
            default: begin
               pos = bound_pos(r.timestamp, r.opcode == OP_UPPER_BOUND);
               if (pos < entries) begin
                  // offset uses the register values current at query time
                  off = 64'(header_bytes) + 64'(record_no[pos]) * 64'(record_bytes);
                  ans.offset = off[OFFSET_W-1:0];
                  ans.found  = 1'b1;
               end
            end
         endcase
         ans.held_count = COUNT_W'(entries);
         owed_rsp = {owed_rsp, ans};
      endfunction

      function void compare_response(rsp_type got);
         rsp_type want;
         if (owed_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected response: offset %0d found %0b count %0d dropped %0b",
                        $realtime, got.offset, got.found, got.held_count, got.dropped);
            end
            return;
         end
         want = owed_rsp.pop_front();
         if (got.offset !== want.offset || got.found !== want.found ||
             got.held_count !== want.held_count || got.dropped !== want.dropped) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: mismatch: want offset %0d found %0b count %0d dropped %0b",
                        $realtime, want.offset, want.found, want.held_count, want.dropped);
               $display("             got  offset %0d found %0b count %0d dropped %0b",
                        got.offset, got.found, got.held_count, got.dropped);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   rsp_type                rsp_payload;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_HEADER_BYTES;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   stamp_index_tracker tracker;
   int unsigned        sender_idle_pct = 0;
   int unsigned        sent = 0;
   int unsigned        cycles = 0;

   sorted_timestamp_index_search_unit #(
      .TABLE_DEPTH (DEPTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Response monitor: the strobe lasts one cycle and cannot be held off.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         tracker.compare_response(rsp_payload);
      end
   end

   // Watchdog against a hung unit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Present one request, holding start until the unit takes it.
   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [STAMP_W-1:0] ts);
      req_type r;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      r.opcode    = op;
      r.timestamp = ts;
      start       <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      tracker.take_request(r);
      sent++;
   endtask

   // Stop sending and wait until every owed response is in.
   task automatic wait_for_answers();
      start <= 1'b0;
      while (tracker.owed_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      wait_for_answers();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_register(idx, value);
   endtask

   // Size register value: extremes often, otherwise any 16-bit pattern.
   function automatic logic [CSR_DATA_W-1:0] pick_size();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return 16'd1;
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   // Small values give ties; the rest spread over the full 64 bits.
   function automatic logic [STAMP_W-1:0] random_stamp();
      case ($urandom_range(3))
         0: return 64'($urandom_range(15));
         1: return {$urandom, $urandom};
         2: return $urandom_range(1) ? '0 : ALL_ONES;
         default: return ALL_ONES - 64'($urandom_range(7));
      endcase
   endfunction

   // Query targets land on, just below or just above held stamps half the time.
   function automatic logic [STAMP_W-1:0] query_target();
      logic [STAMP_W-1:0] s;
      if (tracker.entries > 0 && $urandom_range(1)) begin
         s = tracker.stamps[$urandom_range(tracker.entries - 1)];
         return s + 64'($urandom_range(2)) - 64'd1;
      end
      return random_stamp();
   endfunction

   // Clear, then a mix of appends and queries, with some stray requests.
   task automatic run_episode(input int unsigned max_fill);
      int unsigned fill, asks;
      fill = $urandom_range(max_fill);
      asks = $urandom_range(1, 24);
      send_request(OP_CLEAR, {$urandom, $urandom});
      while (fill + asks > 0) begin
         if ($urandom_range(99) < 8) begin
            send_request(OPCODE_W'($urandom_range(3)), random_stamp());
         end else if (fill > 0 && (asks == 0 || $urandom_range(3) != 0)) begin
            send_request(OP_APPEND, random_stamp());
            fill--;
         end else begin
            send_request($urandom_range(1) ? OP_LOWER_BOUND : OP_UPPER_BOUND, query_target());
            asks--;
         end
      end
   endtask

   initial begin
      logic [STAMP_W-1:0] base;
      int unsigned        k;
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extremes, ties, register change seen at query time.
      send_request(OP_LOWER_BOUND, '0);
      send_request(OP_UPPER_BOUND, ALL_ONES);
      send_request(OP_APPEND, ALL_ONES);
      send_request(OP_APPEND, '0);
      send_request(OP_APPEND, 64'd5);
      send_request(OP_APPEND, 64'd5);
      send_request(OP_APPEND, 64'd5);
      send_request(OP_LOWER_BOUND, 64'd5);
      send_request(OP_UPPER_BOUND, 64'd5);
      send_request(OP_LOWER_BOUND, '0);
      send_request(OP_UPPER_BOUND, '0);
      send_request(OP_LOWER_BOUND, ALL_ONES);
      send_request(OP_UPPER_BOUND, ALL_ONES);
      send_request(OP_APPEND, 64'h5555_5555_5555_5555);
      send_request(OP_APPEND, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(OP_LOWER_BOUND, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(OP_UPPER_BOUND, 64'h5555_5555_5555_5555);
      write_register(CSR_RECORD_BYTES, 16'd3);
      send_request(OP_UPPER_BOUND, 64'h5555_5555_5555_5555);
      send_request(OP_CLEAR, ALL_ONES);
      send_request(OP_LOWER_BOUND, '0);
      send_request(OP_APPEND, 64'd3);
      send_request(OP_UPPER_BOUND, 64'd2);
      send_request(OP_CLEAR, '0);

      // Random episodes under three sender idle rates.
      for (int ph = 0; ph < 3; ph++) begin
         sender_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 51 : 0;
         write_register(CSR_HEADER_BYTES, (ph == 1) ? 16'hFFFF : 16'h0000);
         write_register(CSR_RECORD_BYTES, (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'h0000 : 16'd1);
         while (sent < 23 + 280 * (ph + 1)) begin
            if ($urandom_range(4) == 0) begin
               write_register(CSR_HEADER_BYTES, pick_size());
               write_register(CSR_RECORD_BYTES, pick_size());
            end
            run_episode(40);
         end
      end

      // Full table: ascending stamps in pairs, then appends that must be dropped.
      base = {$urandom, $urandom} >> 1;
      send_request(OP_CLEAR, base);
      for (int unsigned i = 0; i < DEPTH; i++) begin
         send_request(OP_APPEND, base + 64'(i >> 1));
      end
      repeat (4) send_request(OP_APPEND, random_stamp());

      // Largest offsets, then a zero record size.
      write_register(CSR_HEADER_BYTES, 16'hFFFF);
      write_register(CSR_RECORD_BYTES, 16'hFFFF);
      send_request(OP_LOWER_BOUND, '0);
      send_request(OP_LOWER_BOUND, ALL_ONES);
      send_request(OP_UPPER_BOUND, base + 64'(DEPTH / 2 - 2));
      send_request(OP_LOWER_BOUND, base + 64'(DEPTH / 2 - 1));
      send_request(OP_UPPER_BOUND, base + 64'(DEPTH / 2 - 1));
      repeat (16) begin
         k = $urandom_range(DEPTH / 2);
         send_request($urandom_range(1) ? OP_LOWER_BOUND : OP_UPPER_BOUND, base + 64'(k) - 64'd1);
      end
      write_register(CSR_RECORD_BYTES, 16'h0000);
      repeat (4) send_request($urandom_range(1) ? OP_LOWER_BOUND : OP_UPPER_BOUND, query_target());

      // Drain and allow time for any stray strobe.
      wait_for_answers();
      repeat (40) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
